// ----- hdl/pjs_pkg.sv -----
// ============================================================================
// pjs_pkg - shared definitions for the pointer-to-joystick steering block
// Queue geometry, entry layout, command codes, state codes and the steering
// result record passed between the steering unit and the top level.
// ============================================================================
package pjs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    // Entry layout: bit 16 marks a target (x in 15:8, y in 7:0),
    // otherwise a button event with its level in bit 8.
    localparam int ENTRY_W = 17;
    localparam int TGT_BIT = 16;
    localparam int BTN_BIT = 8;

    localparam logic [7:0] STATUS_IDLE = 8'hFC;
    localparam logic [7:0] BUTTON_FLAG = 8'h10;
    localparam logic [7:0] MIN_SPEED   = 8'd3;
    localparam logic [7:0] MAX_SPEED   = 8'd127;

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [2:0] {
        CMD_AXES       = 3'd0,
        CMD_JOY_BUTTON = 3'd1,
        CMD_TARGET     = 3'd2,
        CMD_PTR_BUTTON = 3'd3,
        CMD_END_TRACK  = 3'd4,
        CMD_POLL       = 3'd5,
        CMD_CLEAR      = 3'd6
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic              done;
        logic              load_defl;
        logic signed [7:0] defl_x;
        logic signed [7:0] defl_y;
        logic              touch_valid;
        logic              last_valid;
        logic              load_last;
    } steer_res_t;

    // Wrap base + offs into the queue; base < depth and offs <= depth.
    function automatic ptr_t ptr_add(input ptr_t base, input cnt_t offs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offs);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ----- hdl/pjs_if.sv -----
// ============================================================================
// pjs_if - request and reading channels of the steering block
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ============================================================================
interface pjs_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic signed [7:0] axis_x;
    logic signed [7:0] axis_y;
    logic              button;
    logic [7:0]        target_x;
    logic [7:0]        target_y;
    logic              world_present;
    logic [7:0]        player_x;
    logic [7:0]        player_y;

    modport source (
        output valid, command, axis_x, axis_y, button, target_x, target_y,
               world_present, player_x, player_y,
        input  ready
    );
    modport sink (
        input  valid, command, axis_x, axis_y, button, target_x, target_y,
               world_present, player_x, player_y,
        output ready
    );
endinterface

interface pjs_joy_if;
    logic       valid;
    logic       ready;
    logic [8:0] joy_x;
    logic [8:0] joy_y;
    logic [7:0] port_status;

    modport source (
        output valid, joy_x, joy_y, port_status,
        input  ready
    );
    modport sink (
        input  valid, joy_x, joy_y, port_status,
        output ready
    );
endinterface

// ----- hdl/pjs_event_ram.sv -----
// ============================================================================
// pjs_event_ram - event queue storage
// One write port, one read port with registered read data.
// ============================================================================
module pjs_event_ram import pjs_pkg::*;
(
    input  logic   clk,
    input  logic   we,
    input  ptr_t   waddr,
    input  entry_t wdata,
    input  ptr_t   raddr,
    output entry_t rdata
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/pjs_steer_calc.sv -----
// ============================================================================
// pjs_steer_calc - steering step for a queued target
// Derives axis speeds from the distance to the target and decides whether
// the target is reached, the player has stopped moving or no world is present.
// ============================================================================
module pjs_steer_calc import pjs_pkg::*;
(
    input  entry_t     entry,
    input  logic       world_present,
    input  logic [7:0] player_x,
    input  logic [7:0] player_y,
    input  logic       last_pos_valid,
    input  logic [7:0] last_player_x,
    input  logic [7:0] last_player_y,
    output steer_res_t res
);

    // 3 + (|d| - 1) / 2, capped, with the sign of d
    function automatic logic [7:0] speed_for(input logic signed [8:0] diff);
        logic [8:0] mag;
        logic [8:0] spd;
        mag = diff[8] ? 9'(-diff) : 9'(diff);
        spd = 9'(MIN_SPEED) + ((mag - 9'd1) >> 1);
        if (spd > 9'(MAX_SPEED))
        begin
            spd = 9'(MAX_SPEED);
        end
        if (mag == 9'd0)
        begin
            spd = 9'd0;
        end
        return diff[8] ? (~spd[7:0] + 8'd1) : spd[7:0];
    endfunction

    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic              arrived;
    logic              stuck;

    always_comb
    begin
        dx      = $signed({1'b0, entry[15:8]}) - $signed({1'b0, player_x});
        dy      = $signed({1'b0, player_y}) - $signed({1'b0, entry[7:0]});
        arrived = (dx == 9'sd0) && (dy == 9'sd0);
        stuck   = last_pos_valid && (last_player_x == player_x)
                  && (last_player_y == player_y);

        res.done        = !world_present || arrived || stuck;
        res.load_defl   = world_present;
        res.defl_x      = $signed(speed_for(dx));
        res.defl_y      = $signed(speed_for(dy));
        res.touch_valid = world_present;
        res.last_valid  = !arrived;
        res.load_last   = world_present && !arrived;
    end

endmodule

// ----- hdl/pointer_to_joystick_steering_top.sv -----
// ============================================================================
// pointer_to_joystick_steering_top - pointer events to joystick readings
// Queues pointer targets and button events and turns them into emulated
// analog axis readings and a game port status byte on each poll.
// ============================================================================
// Usage:
//   cmd  - request channel (valid/ready). Each request carries a command and
//          its operands; unused operands are ignored.
//   joy  - reading channel (valid/ready). Only a poll request produces a
//          reading: joy_x, joy_y and port_status.
//   cfg_we / cfg_wdata - write the joystick center; write only while idle.
// Timing:
//   Non-poll requests are taken back to back while the block is idle.
//   A poll reads the queue front from the event RAM (registered read data)
//   when it is accepted and handles it in the exec state, where the
//   reading is loaded into the output register. No request is taken
//   while a poll waits in the exec state.
//   The output register frees the request side: new requests are taken
//   while a reading waits. A poll whose reading cannot be loaded because
//   the previous one is still unclaimed holds in the exec state.
// Reset:
//   Queue empty, deflections and button state zero, center 64. The RAM is
//   not cleared; only entries between head and tail are ever used.
// ============================================================================
module pointer_to_joystick_steering_top import pjs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    pjs_cmd_if.sink     cmd,
    pjs_joy_if.source   joy
);

    // Control state
    state_t            state_reg,      state_next;
    ptr_t              head_reg,       head_next;
    cnt_t              count_reg,      count_next;
    logic              back_tgt_reg,   back_tgt_next;
    logic signed [7:0] defl_x_reg,     defl_x_next;
    logic signed [7:0] defl_y_reg,     defl_y_next;
    logic              held_reg,       held_next;
    logic              latched_reg,    latched_next;
    logic              last_valid_reg, last_valid_next;
    logic [7:0]        last_x_reg,     last_x_next;
    logic [7:0]        last_y_reg,     last_y_next;
    logic [7:0]        center_reg,     center_next;
    logic              out_valid_reg,  out_valid_next;

    // Payload: poll operands held for the handling cycle, and the reading
    logic              world_reg,      world_next;
    logic [7:0]        px_reg,         px_next;
    logic [7:0]        py_reg,         py_next;
    logic [8:0]        out_x_reg,      out_x_next;
    logic [8:0]        out_y_reg,      out_y_next;
    logic [7:0]        out_status_reg, out_status_next;

    // Event RAM port
    logic       ram_we;
    ptr_t       ram_waddr;
    entry_t     ram_wdata;
    entry_t     front_entry;

    logic       cmd_fire;
    logic       out_free;
    logic       full;
    ptr_t       push_idx;
    ptr_t       back_idx;
    steer_res_t steer;

    function automatic logic [8:0] clamp_axis(input logic signed [7:0] d,
                                              input logic [7:0] c);
        logic signed [10:0] v;
        logic signed [10:0] lim;
        v   = 11'(d) + $signed({3'b000, c});
        lim = $signed({2'b00, c, 1'b0});
        if (v > lim)
        begin
            v = lim;
        end
        if (v < 11'sd0)
        begin
            v = 11'sd0;
        end
        return v[8:0];
    endfunction

    pjs_event_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (front_entry)
    );

    pjs_steer_calc u_steer (
        .entry          (front_entry),
        .world_present  (world_reg),
        .player_x       (px_reg),
        .player_y       (py_reg),
        .last_pos_valid (last_valid_reg),
        .last_player_x  (last_x_reg),
        .last_player_y  (last_y_reg),
        .res            (steer)
    );

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign out_free    = !out_valid_reg || joy.ready;
    assign full        = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push_idx    = ptr_add(head_reg, count_reg);
    assign back_idx    = ptr_add(head_reg, count_reg - CNT_W'(1));

    assign joy.valid       = out_valid_reg;
    assign joy.joy_x       = out_x_reg;
    assign joy.joy_y       = out_y_reg;
    assign joy.port_status = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        back_tgt_next   = back_tgt_reg;
        defl_x_next     = defl_x_reg;
        defl_y_next     = defl_y_reg;
        held_next       = held_reg;
        latched_next    = latched_reg;
        last_valid_next = last_valid_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        center_next     = cfg_we ? cfg_wdata : center_reg;
        out_valid_next  = out_valid_reg;
        world_next      = world_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = push_idx;
        ram_wdata       = {1'b1, cmd.target_x, cmd.target_y};

        // Drop the reading once the receiver takes it
        if (joy.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd_fire)
        begin
            case (cmd_t'(cmd.command))
                CMD_AXES:
                begin
                    head_next   = '0;
                    count_next  = '0;
                    defl_x_next = cmd.axis_x;
                    defl_y_next = cmd.axis_y;
                end
                CMD_JOY_BUTTON:
                begin
                    head_next    = '0;
                    count_next   = '0;
                    held_next    = cmd.button;
                    latched_next = latched_reg || cmd.button;
                end
                CMD_TARGET:
                begin
                    ram_we = 1'b1;
                    if ((count_reg != '0) && back_tgt_reg)
                    begin
                        // Overwrite the target still waiting at the back
                        ram_waddr = back_idx;
                    end
                    else if (full)
                    begin
                        // Flush the queue, then append
                        ram_waddr     = '0;
                        head_next     = '0;
                        count_next    = CNT_W'(1);
                        back_tgt_next = 1'b1;
                    end
                    else
                    begin
                        count_next    = count_reg + CNT_W'(1);
                        back_tgt_next = 1'b1;
                    end
                end
                CMD_PTR_BUTTON:
                begin
                    ram_wdata = ENTRY_W'({cmd.button, 8'h00});
                    if (!full)
                    begin
                        ram_we        = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        back_tgt_next = 1'b0;
                    end
                end
                CMD_END_TRACK, CMD_CLEAR:
                begin
                    head_next    = '0;
                    count_next   = '0;
                    defl_x_next  = '0;
                    defl_y_next  = '0;
                    held_next    = 1'b0;
                    latched_next = 1'b0;
                end
                CMD_POLL:
                begin
                    // Front entry is read this edge; it is handled in the exec state
                    world_next = cmd.world_present;
                    px_next    = cmd.player_x;
                    py_next    = cmd.player_y;
                    state_next = ST_EXEC;
                end
                default:
                begin
                end
            endcase
        end

        if ((state_reg == ST_EXEC) && out_free)
        begin
            if (count_reg != '0)
            begin
                if (front_entry[TGT_BIT])
                begin
                    if (steer.load_defl)
                    begin
                        defl_x_next = steer.defl_x;
                        defl_y_next = steer.defl_y;
                    end
                    if (steer.touch_valid)
                    begin
                        last_valid_next = steer.last_valid;
                    end
                    if (steer.load_last)
                    begin
                        last_x_next = px_reg;
                        last_y_next = py_reg;
                    end
                    if (steer.done)
                    begin
                        head_next  = ptr_add(head_reg, CNT_W'(1));
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    held_next  = front_entry[BTN_BIT];
                    head_next  = ptr_add(head_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                end
            end
            out_x_next      = clamp_axis(defl_x_next, center_reg);
            out_y_next      = clamp_axis(defl_y_next, center_reg);
            out_status_next = (held_next || latched_reg)
                              ? (STATUS_IDLE & ~BUTTON_FLAG) : STATUS_IDLE;
            latched_next    = 1'b0;
            out_valid_next  = 1'b1;
            state_next      = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            back_tgt_reg   <= 1'b0;
            defl_x_reg     <= '0;
            defl_y_reg     <= '0;
            held_reg       <= 1'b0;
            latched_reg    <= 1'b0;
            last_valid_reg <= 1'b0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            center_reg     <= 8'd64;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            back_tgt_reg   <= back_tgt_next;
            defl_x_reg     <= defl_x_next;
            defl_y_reg     <= defl_y_next;
            held_reg       <= held_next;
            latched_reg    <= latched_next;
            last_valid_reg <= last_valid_next;
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            center_reg     <= center_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        world_reg      <= world_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_status_reg <= out_status_next;
    end

    // Queue occupancy never exceeds its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // Head pointer stays inside the queue
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= PTR_W'(QUEUE_DEPTH - 1))
        else $error("queue head out of range");

    // An accepted poll puts the block in the exec state in the following cycle
    a_poll_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.command == CMD_POLL)) |=> (state_reg == ST_EXEC))
        else $error("poll not handled after acceptance");

    // A reading only appears from the handling cycle of a poll
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("reading without a poll");

endmodule

// ----- tb/sv/joystick_reading_checker.sv -----
// ============================================================================
// joystick_reading_checker - reading predictor and scoreboard
// Watches the request and reading channels of the steering block, keeps its
// own copy of the event queue, deflections and button state, works out the
// reading for every accepted poll and compares it with what the block sends.
// ============================================================================
module joystick_reading_checker import pjs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    pjs_cmd_if         cmd,
    pjs_joy_if         joy,
    output int         mismatches,
    output int         readings_due,
    output int         readings_checked,
    output int         full_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CENTER_AT_RESET = 8'd64;
    localparam int         MAX_REPORTS     = 10;

    typedef struct packed {
        logic [8:0] joy_x;
        logic [8:0] joy_y;
        logic [7:0] port_status;
    } reading_t;

    entry_t            event_q [QUEUE_DEPTH];
    ptr_t              q_head;
    cnt_t              q_count;
    logic signed [7:0] defl_x;
    logic signed [7:0] defl_y;
    logic              btn_held;
    logic              btn_latched;
    logic              last_valid;
    logic [7:0]        last_px;
    logic [7:0]        last_py;
    logic [7:0]        center;
    reading_t          expected_q [$];

    // speed grows with distance, saturates at the top speed
    function automatic logic signed [7:0] axis_speed(input int diff);
        int mag;
        int s;
        mag = (diff < 0) ? -diff : diff;
        if (mag == 0)
            return '0;
        s = int'(MIN_SPEED) + ((mag - 1) >> 1);
        if (s > int'(MAX_SPEED))
            s = int'(MAX_SPEED);
        return (diff < 0) ? 8'(-s) : 8'(s);
    endfunction

    function automatic logic [8:0] axis_reading(input logic signed [7:0] defl);
        int c;
        int v;
        c = int'(center);
        v = int'(defl) + c;
        if (v > 2 * c)
            v = 2 * c;
        if (v < 0)
            v = 0;
        return 9'(v);
    endfunction

    // steer toward the target; return 1 when the target is done with
    function automatic logic steer_to_target(input logic [7:0] tx, input logic [7:0] ty,
                                             input logic world,
                                             input logic [7:0] px, input logic [7:0] py);
        int   dx;
        int   dy;
        logic stuck;
        if (!world)
            return 1'b1;
        dx = int'(tx) - int'(px);
        dy = int'(py) - int'(ty);
        defl_x = axis_speed(dx);
        defl_y = axis_speed(dy);
        if (dx == 0 && dy == 0)
        begin
            last_valid = 1'b0;
            return 1'b1;
        end
        stuck = last_valid && last_px == px && last_py == py;
        last_px    = px;
        last_py    = py;
        last_valid = 1'b1;
        return stuck;
    endfunction

    task automatic drop_queue();
        q_head  = '0;
        q_count = '0;
    endtask

    task automatic idle_controls();
        drop_queue();
        defl_x      = '0;
        defl_y      = '0;
        btn_held    = 1'b0;
        btn_latched = 1'b0;
    endtask

    task automatic push_event(input entry_t e);
        event_q[ptr_t'((int'(q_head) + int'(q_count)) % QUEUE_DEPTH)] = e;
        q_count = q_count + 1'b1;
    endtask

    task automatic predict_request();
        ptr_t     back_slot;
        entry_t   front;
        logic     pressed;
        reading_t r;
        back_slot = ptr_t'((int'(q_head) + int'(q_count) + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
        case (cmd.command)
            CMD_AXES:
            begin
                drop_queue();
                defl_x = cmd.axis_x;
                defl_y = cmd.axis_y;
            end
            CMD_JOY_BUTTON:
            begin
                drop_queue();
                btn_held    = cmd.button;
                btn_latched = btn_latched | cmd.button;
            end
            CMD_TARGET:
            begin
                // a target waiting at the back is replaced, not queued behind
                if (q_count != 0 && event_q[back_slot][TGT_BIT])
                    event_q[back_slot] = {1'b1, cmd.target_x, cmd.target_y};
                else
                begin
                    if (q_count >= QUEUE_DEPTH)
                    begin
                        full_hits++;
                        drop_queue();
                    end
                    push_event({1'b1, cmd.target_x, cmd.target_y});
                end
            end
            CMD_PTR_BUTTON:
            begin
                if (q_count < QUEUE_DEPTH)
                    push_event(entry_t'(cmd.button) << BTN_BIT);
                else
                    full_hits++;
            end
            CMD_END_TRACK, CMD_CLEAR:
                idle_controls();
            CMD_POLL:
            begin
                if (q_count != 0)
                begin
                    front = event_q[q_head];
                    if (front[TGT_BIT])
                    begin
                        if (steer_to_target(front[15:8], front[7:0], cmd.world_present,
                                            cmd.player_x, cmd.player_y))
                        begin
                            q_head  = ptr_t'((int'(q_head) + 1) % QUEUE_DEPTH);
                            q_count = q_count - 1'b1;
                        end
                    end
                    else
                    begin
                        btn_held = front[BTN_BIT];
                        q_head   = ptr_t'((int'(q_head) + 1) % QUEUE_DEPTH);
                        q_count  = q_count - 1'b1;
                    end
                end
                pressed       = btn_held | btn_latched;
                btn_latched   = 1'b0;
                r.joy_x       = axis_reading(defl_x);
                r.joy_y       = axis_reading(defl_y);
                r.port_status = pressed ? (STATUS_IDLE & ~BUTTON_FLAG) : STATUS_IDLE;
                expected_q    = {expected_q, r};
            end
            default:
                ;
        endcase
    endtask

    task automatic check_reading();
        reading_t want;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: reading with no poll pending: x=%0d y=%0d status=%02h",
                         $realtime, joy.joy_x, joy.joy_y, joy.port_status);
        end
        else
        begin
            want = expected_q[0];
            expected_q.delete(0);
            readings_checked++;
            if (joy.joy_x !== want.joy_x || joy.joy_y !== want.joy_y ||
                joy.port_status !== want.port_status)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: want x=%0d y=%0d st=%02h, got x=%0d y=%0d st=%02h",
                             $realtime, want.joy_x, want.joy_y, want.port_status,
                             joy.joy_x, joy.joy_y, joy.port_status);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_controls();
            last_valid = 1'b0;
            last_px    = '0;
            last_py    = '0;
            center     = CENTER_AT_RESET;
            expected_q.delete();
            readings_due     = 0;
            mismatches       = 0;
            readings_checked = 0;
            full_hits        = 0;
        end
        else
        begin
            // compare first: a reading never belongs to a poll taken at the same edge
            if (joy.valid && joy.ready)
                check_reading();
            if (cfg_we)
                center = cfg_wdata;
            if (cmd.valid && cmd.ready)
                predict_request();
            readings_due = expected_q.size();
        end
    end

endmodule

// ----- tb/sv/pointer_to_joystick_steering_top_test.sv -----
// ============================================================================
// pointer_to_joystick_steering_top_test - steering block regression
// Drives directed and random request streams into the steering block under
// several joystick center settings, with random idling on both channels,
// and lets the reading checker score every poll.
// ============================================================================
module pointer_to_joystick_steering_top_test import pjs_pkg::*;
    ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_PERIOD     = 8;
    localparam int         RESET_CYCLES   = 3;
    localparam int         TOTAL_REQUESTS = 850;
    localparam int         NUM_PHASES     = 6;
    localparam int         LONG_HOLD      = 300;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] CMD_UNUSED     = 3'd7;

    typedef struct {
        logic [2:0]        command;
        logic signed [7:0] axis_x;
        logic signed [7:0] axis_y;
        logic              button;
        logic [7:0]        target_x;
        logic [7:0]        target_y;
        logic              world_present;
        logic [7:0]        player_x;
        logic [7:0]        player_y;
    } request_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = '0;

    pjs_cmd_if cmd_ch ();
    pjs_joy_if joy_ch ();

    int mismatches;
    int readings_due;
    int readings_checked;
    int full_hits;

    // stimulus bookkeeping
    int         requests_sent   = 0;
    int         polls_sent      = 0;
    int         center_settings = 1;
    int         send_gap_pct    = 0;
    int         ready_stall_pct = 0;
    bit         tail_calm       = 1'b0;
    int         hold_requests   = 0;
    logic [7:0] player_x        = 8'd128;
    logic [7:0] player_y        = 8'd128;

    always
    begin
        #(CLK_PERIOD / 2) clk = ~clk;
    end

    pointer_to_joystick_steering_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .joy       (joy_ch)
    );

    joystick_reading_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd_ch),
        .joy              (joy_ch),
        .mismatches       (mismatches),
        .readings_due     (readings_due),
        .readings_checked (readings_checked),
        .full_hits        (full_hits)
    );

    // Every operand is random; callers override the ones the command uses,
    // so the unused fields still toggle every bit.
    function automatic request_t random_request(input logic [2:0] command);
        request_t r;
        r.command       = command;
        r.axis_x        = 8'($urandom);
        r.axis_y        = 8'($urandom);
        r.button        = 1'($urandom);
        r.target_x      = 8'($urandom);
        r.target_y      = 8'($urandom);
        r.world_present = 1'($urandom);
        r.player_x      = 8'($urandom);
        r.player_y      = 8'($urandom);
        return r;
    endfunction

    // Pick a coordinate a short distance away, clamped to the screen.
    function automatic logic [7:0] nearby(input logic [7:0] v);
        int t;
        t = int'(v) + int'($urandom_range(24)) - 12;
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return 8'(t);
    endfunction

    // Move the player part of the way toward the goal.
    function automatic logic [7:0] approach(input logic [7:0] cur, input logic [7:0] goal);
        if (cur < goal)
            return cur + 8'($urandom_range(1, goal - cur));
        if (cur > goal)
            return cur - 8'($urandom_range(1, cur - goal));
        return cur;
    endfunction

    // Offer one request at the falling edge, optionally after an idle burst,
    // and hold it until the block takes it. Returns at the next falling edge
    // so that the caller can present the next request right away.
    task automatic send_request(input request_t r);
        if (!tail_calm && $urandom_range(99) < send_gap_pct)
        begin
            cmd_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        cmd_ch.valid         = 1'b1;
        cmd_ch.command       = r.command;
        cmd_ch.axis_x        = r.axis_x;
        cmd_ch.axis_y        = r.axis_y;
        cmd_ch.button        = r.button;
        cmd_ch.target_x      = r.target_x;
        cmd_ch.target_y      = r.target_y;
        cmd_ch.world_present = r.world_present;
        cmd_ch.player_x      = r.player_x;
        cmd_ch.player_y      = r.player_y;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
        if (r.command != CMD_UNUSED)
            requests_sent++;
        if (r.command == CMD_POLL)
            polls_sent++;
    endtask

    task automatic send_poll(input logic world, input logic [7:0] px, input logic [7:0] py);
        request_t r;
        r               = random_request(CMD_POLL);
        r.world_present = world;
        r.player_x      = px;
        r.player_y      = py;
        send_request(r);
    endtask

    task automatic send_target(input logic [7:0] tx, input logic [7:0] ty);
        request_t r;
        r          = random_request(CMD_TARGET);
        r.target_x = tx;
        r.target_y = ty;
        send_request(r);
    endtask

    task automatic send_button(input logic [2:0] command, input logic level);
        request_t r;
        r        = random_request(command);
        r.button = level;
        send_request(r);
    endtask

    task automatic send_axes(input logic signed [7:0] ax, input logic signed [7:0] ay);
        request_t r;
        r        = random_request(CMD_AXES);
        r.axis_x = ax;
        r.axis_y = ay;
        send_request(r);
    endtask

    // Drop valid and hold until every poll has been answered, then let the
    // block settle, since non-poll requests leave nothing to wait for.
    task automatic wait_idle();
        cmd_ch.valid = 1'b0;
        while (readings_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_center(input logic [7:0] value);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        center_settings++;
    endtask

    // One random burst. Most bursts are well-formed steering, button, joystick
    // or clearing sequences with random content; the rest fill the queue to or
    // past its depth or throw arbitrary commands at the block.
    task automatic random_burst();
        logic [7:0] tx;
        logic [7:0] ty;
        bit         last_was_target;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // steering session: mostly nearby targets, some far ones
            if ($urandom_range(4) == 0)
            begin
                tx = 8'($urandom);
                ty = 8'($urandom);
            end
            else
            begin
                tx = nearby(player_x);
                ty = nearby(player_y);
            end
            send_target(tx, ty);
            if ($urandom_range(3) == 0)
            begin
                // replace the target before the first poll
                tx = nearby(tx);
                ty = nearby(ty);
                send_target(tx, ty);
            end
            repeat ($urandom_range(2, 8))
            begin
                case ($urandom_range(4))
                    0:
                        ; // player stuck in place
                    1:
                    begin
                        player_x = tx;
                        player_y = ty;
                    end
                    default:
                    begin
                        player_x = approach(player_x, tx);
                        player_y = approach(player_y, ty);
                    end
                endcase
                send_poll($urandom_range(9) != 0, player_x, player_y);
            end
        end
        else if (pick < 52)
        begin
            // fill the queue to and past its depth, mixing entry kinds
            last_was_target = 1'b0;
            repeat ($urandom_range(15, 20))
            begin
                if (!last_was_target && $urandom_range(2) == 0)
                begin
                    send_target(8'($urandom), 8'($urandom));
                    last_was_target = 1'b1;
                end
                else
                begin
                    send_button(CMD_PTR_BUTTON, 1'($urandom));
                    last_was_target = 1'b0;
                end
            end
            if ($urandom_range(1) == 0)
                send_target(8'($urandom), 8'($urandom));
            else
                send_button(CMD_PTR_BUTTON, 1'($urandom));
            repeat ($urandom_range(1, 5)) send_poll(1'($urandom), player_x, player_y);
        end
        else if (pick < 65)
        begin
            // button traffic, pointer and joystick, between polls
            repeat ($urandom_range(1, 5))
            begin
                send_button(($urandom_range(3) == 0) ? CMD_JOY_BUTTON : CMD_PTR_BUTTON,
                            1'($urandom));
                if ($urandom_range(1) == 0)
                    send_poll(1'($urandom), player_x, player_y);
            end
        end
        else if (pick < 77)
        begin
            // direct joystick control
            send_axes(8'($urandom), 8'($urandom));
            repeat ($urandom_range(1, 2)) send_poll(1'($urandom), player_x, player_y);
            send_button(CMD_JOY_BUTTON, 1'($urandom));
            send_poll(1'($urandom), player_x, player_y);
        end
        else if (pick < 85)
        begin
            send_request(random_request(($urandom_range(1) == 0) ? CMD_END_TRACK : CMD_CLEAR));
            send_poll(1'($urandom), player_x, player_y);
        end
        else
        begin
            // noise: any command, unused code included, any operands
            repeat ($urandom_range(1, 4)) send_request(random_request(3'($urandom_range(7))));
            player_x = 8'($urandom);
            player_y = 8'($urandom);
        end
    endtask

    // Reading side: random stall bursts, one long hold-off on request, and
    // none at all once the tail of the run starts.
    initial
    begin
        int holds_served;
        holds_served = 0;
        joy_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                joy_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_served++;
            end
            else if (!tail_calm && $urandom_range(99) < ready_stall_pct)
            begin
                joy_ch.ready = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
                joy_ch.ready = 1'b1;
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (joy_ch.valid && joy_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [7:0] phase_centers [NUM_PHASES];
        cmd_ch.valid         = 1'b0;
        cmd_ch.command       = CMD_AXES;
        cmd_ch.axis_x        = '0;
        cmd_ch.axis_y        = '0;
        cmd_ch.button        = 1'b0;
        cmd_ch.target_x      = '0;
        cmd_ch.target_y      = '0;
        cmd_ch.world_present = 1'b0;
        cmd_ch.player_x      = '0;
        cmd_ch.player_y      = '0;

        // extremes first, a zero center, then a random and a mid setting,
        // and back to the reset value for the tail
        phase_centers = '{8'd255, 8'd1, 8'd0, 8'd0, 8'd128, 8'd64};
        phase_centers[3] = 8'($urandom_range(2, 254));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, reset center. Poll on an empty queue reads rest.
        send_poll(1'($urandom), 8'($urandom), 8'($urandom));
        // Axis extremes clamp at both ends of the range.
        send_axes(8'h80, 8'h7F);
        send_poll(1'($urandom), 8'($urandom), 8'($urandom));
        send_axes(8'h7F, 8'h80);
        send_poll(1'($urandom), 8'($urandom), 8'($urandom));
        // A short joystick press is latched until the next poll.
        send_button(CMD_JOY_BUTTON, 1'b1);
        send_button(CMD_JOY_BUTTON, 1'b0);
        send_poll(1'($urandom), 8'($urandom), 8'($urandom));
        send_poll(1'($urandom), 8'($urandom), 8'($urandom));
        // Far target saturates speed; second poll at the same spot is stuck.
        send_target(8'd255, 8'd0);
        send_poll(1'b1, 8'd0, 8'd255);
        send_poll(1'b1, 8'd0, 8'd255);
        // Without a world the target completes at once.
        send_target(8'd0, 8'd255);
        send_poll(1'b0, 8'd0, 8'd0);
        // Target replaced at the back, then reached exactly.
        send_target(8'd10, 8'd10);
        send_target(8'd20, 8'd20);
        send_poll(1'b1, 8'd20, 8'd20);
        // Pointer button events go through the queue.
        send_button(CMD_PTR_BUTTON, 1'b1);
        send_poll(1'($urandom), 8'($urandom), 8'($urandom));
        send_button(CMD_PTR_BUTTON, 1'b0);
        send_poll(1'($urandom), 8'($urandom), 8'($urandom));
        // End tracking and clear zero the deflections; the unused code is a no-op.
        send_axes(8'sd5, -8'sd5);
        send_request(random_request(CMD_END_TRACK));
        send_poll(1'($urandom), 8'($urandom), 8'($urandom));
        send_axes(-8'sd9, 8'sd9);
        send_request(random_request(CMD_CLEAR));
        send_request(random_request(CMD_UNUSED));
        send_poll(1'($urandom), 8'($urandom), 8'($urandom));

        // Random part, one center setting per phase.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_center(phase_centers[p]);
            send_gap_pct    = 15 * $urandom_range(0, 3);
            ready_stall_pct = 15 * $urandom_range(0, 3);
            if (p == NUM_PHASES - 1)
                tail_calm = 1'b1;
            if (p == 1)
            begin
                // hold the reading side off while polls keep coming, so the
                // block backs up and stalls its request side
                hold_requests++;
                repeat (40) send_poll(1'($urandom), player_x, player_y);
            end
            while (requests_sent < TOTAL_REQUESTS * (p + 1) / NUM_PHASES)
                random_burst();
        end

        wait_idle();

        $display("Run covered %0d requests, %0d of them polls, under %0d joystick centers.",
                 requests_sent, polls_sent, center_settings);
        $display("%0d readings compared; requests met a full event queue %0d times.",
                 readings_checked, full_hits);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
